// ===== src/depth_to_point_backprojection_defines.svh =====
// assertion macros for the depth back-projection checker
// no dependencies; included by the checker file only
`ifndef DEPTH_TO_POINT_BACKPROJECTION_DEFINES_SVH
`define DEPTH_TO_POINT_BACKPROJECTION_DEFINES_SVH

// property checked at every edge outside reset
`define DTPB_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked at every edge, reset included
`define DTPB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== src/dtpb_pkg.sv =====
// shared constants, types and helpers of the depth back-projection block
// no dependencies; used by every other file but the assertion macro header
package dtpb_pkg;

    // frame geometry
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int CNT_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SIZE_W     = 13;

    // field widths
    localparam int DEPTH_W = 16;
    localparam int CFG_W   = 63;
    localparam int COEF_W  = 20;
    localparam int OFS_W   = 24;
    localparam int IDX_W   = 25;
    localparam int PT_W    = 24;
    localparam int REGI_W  = 3;

    // register indexes
    localparam logic [REGI_W-1:0] REG_RAY_X  = 3'd0;
    localparam logic [REGI_W-1:0] REG_RAY_Y  = 3'd1;
    localparam logic [REGI_W-1:0] REG_RAY_Z  = 3'd2;
    localparam logic [REGI_W-1:0] REG_OFFSET = 3'd3;
    localparam logic [REGI_W-1:0] REG_WIDTH  = 3'd4;
    localparam logic [REGI_W-1:0] REG_HEIGHT = 3'd5;
    localparam logic [REGI_W-1:0] REG_CLOUD  = 3'd6;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd480;

    // scaling: offset is Q16.4, ray product carries 19 fraction bits
    localparam int OFS_SHIFT = 15;
    // divide by 8000 = 64 * 125, rounding half away from zero
    localparam int DIV_SHIFT   = 6;
    localparam int ROUND_ADD   = 4000;
    localparam int T_W         = 30;
    localparam int RECIP_W     = 31;
    localparam int RECIP_SHIFT = 37;
    localparam logic [RECIP_W-1:0] RECIP_125 = 31'd1099511628;

    // saturation limits (magnitudes)
    localparam logic [PT_W-1:0] Q_POS_MAX = 24'h7FFFFF;
    localparam logic [PT_W-1:0] Q_NEG_MAX = 24'h800000;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [CNT_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic               frame_end;
    } t_job;

    typedef struct packed {
        logic [CFG_W-1:0]  ray_x;
        logic [CFG_W-1:0]  ray_y;
        logic [CFG_W-1:0]  ray_z;
        logic [CFG_W-1:0]  ofs;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [OFS_W-1:0]  cloud_offset;
    } t_cfg;

    // clamp a frame size to [1, mx]
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W:0] mx);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if ({1'b0, v} > mx) begin
            r = mx[SIZE_W-1:0];
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== src/dtpb_ifs.sv =====
// channel interfaces: depth samples in, points out, register writes
// depends on dtpb_pkg
interface dtpb_px_if import dtpb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] depth_mm;
    logic               frame_start;
    modport source (output valid, depth_mm, frame_start, input ready);
    modport sink   (input valid, depth_mm, frame_start, output ready);
endinterface

interface dtpb_pt_if import dtpb_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic signed [PT_W-1:0] point_z;
    logic [IDX_W-1:0]       point_index;
    logic                   clipped;
    logic                   frame_end;
    modport source (output valid, point_x, point_y, point_z, point_index, clipped,
                    frame_end, input ready);
    modport sink   (input valid, point_x, point_y, point_z, point_index, clipped,
                    frame_end, output ready);
endinterface

interface dtpb_cfg_if import dtpb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REGI_W-1:0] index;
    logic [CFG_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/dtpb_queue.sv =====
// short job queue between front and back, register based
// depends on dtpb_pkg
module dtpb_queue import dtpb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_wdata,
    output logic o_full,
    input  logic i_pop,
    output t_job o_rdata,
    output logic o_empty
);

    t_job             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr, n_wr;
    logic [QAW-1:0]   r_rd, n_rd;
    logic [QAW:0]     r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and fill count update
    always_comb begin
        n_wr  = do_push ? r_wr + QAW'(1) : r_wr;
        n_rd  = do_pop ? r_rd + QAW'(1) : r_rd;
        n_cnt = r_cnt + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

// ===== src/dtpb_front.sv =====
// front end: accepts depth samples, tracks column and row, marks frame end
// depends on dtpb_pkg, dtpb_ifs
module dtpb_front import dtpb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dtpb_px_if.sink   i_px,
    input  t_cfg      i_cfg,
    input  logic      i_full,
    output logic      o_push,
    output t_job      o_job
);

    logic [CNT_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [CNT_W-1:0]  col_cur;
    logic [ROW_W-1:0]  row_cur;
    logic [SIZE_W-1:0] w_m1;
    logic [SIZE_W-1:0] h_m1;
    logic              last_col;
    logic              last_row;

    assign i_px.ready = !i_full;
    assign o_push     = i_px.valid && !i_full;

    // position of this sample, frame start restarts the raster
    always_comb begin
        col_cur  = i_px.frame_start ? '0 : r_col;
        row_cur  = i_px.frame_start ? '0 : r_row;
        w_m1     = i_cfg.width - SIZE_W'(1);
        h_m1     = i_cfg.height - SIZE_W'(1);
        last_col = SIZE_W'(col_cur) >= w_m1;
        last_row = SIZE_W'(row_cur) >= h_m1;
        n_col    = last_col ? '0 : col_cur + CNT_W'(1);
        n_row    = last_col ? (last_row ? '0 : row_cur + ROW_W'(1)) : row_cur;
    end

    // job handed to the queue
    always_comb begin
        o_job.depth     = i_px.depth_mm;
        o_job.col       = col_cur;
        o_job.row       = row_cur;
        o_job.frame_end = last_col && last_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== src/dtpb_axis.sv =====
// one coordinate lane: ray, depth scaling, offset, divide by 8000, saturate
// depends on dtpb_pkg
module dtpb_axis import dtpb_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [CFG_W-1:0]         i_coef,
    input  logic signed [COEF_W-1:0] i_ofs,
    input  logic [CNT_W-1:0]         i_col,
    input  logic [ROW_W-1:0]         i_row,
    input  logic [DEPTH_W-1:0]       i_depth,
    output logic signed [PT_W-1:0]   o_coord,
    output logic                     o_sat
);

    localparam int PC_W   = COEF_W + CNT_W + 1;
    localparam int PR_W   = COEF_W + ROW_W + 1;
    localparam int RAY_W  = ((PC_W > PR_W) ? PC_W : PR_W) + 2;
    localparam int PROD_W = RAY_W + DEPTH_W + 1;
    localparam int S_W    = PROD_W + 1;

    logic signed [PC_W-1:0]   r_p0;
    logic signed [PR_W-1:0]   r_p1;
    logic signed [COEF_W-1:0] r_c2;
    logic signed [RAY_W-1:0]  r_ray;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [S_W-1:0]    r_s;
    logic [DEPTH_W-1:0]       r_d1, r_d2;
    logic signed [COEF_W-1:0] r_b1, r_b2, r_b3;
    logic [T_W-1:0]           r_t;
    logic                     r_big5, r_neg5;
    logic [PT_W-1:0]          r_q;
    logic                     r_big6, r_neg6;

    logic signed [COEF_W-1:0] c0, c1, c2;
    logic                     s_neg;
    logic [S_W-1:0]           u;
    logic [T_W+RECIP_W-1:0]   m;
    logic [PT_W-1:0]          q_lim;
    logic [PT_W-1:0]          q_sel;

    assign c0 = $signed(i_coef[0 +: COEF_W]);
    assign c1 = $signed(i_coef[COEF_W +: COEF_W]);
    assign c2 = $signed(i_coef[2*COEF_W +: COEF_W]);

    // rounding add on the magnitude: -s + 4000 is ~s + 4001
    always_comb begin
        s_neg = r_s[S_W-1];
        u     = (s_neg ? ~$unsigned(r_s) : $unsigned(r_s))
              + (s_neg ? S_W'(ROUND_ADD + 1) : S_W'(ROUND_ADD));
        m     = r_t * RECIP_125;
    end

    // saturation and sign
    always_comb begin
        q_lim   = r_neg6 ? Q_NEG_MAX : Q_POS_MAX;
        o_sat   = r_big6 || (r_q > q_lim);
        q_sel   = o_sat ? q_lim : r_q;
        o_coord = r_neg6 ? -$signed(q_sel) : $signed(q_sel);
    end

    // lane pipeline, advances with the back end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // partial products of the ray
            r_p0   <= c0 * $signed({1'b0, i_col});
            r_p1   <= c1 * $signed({1'b0, i_row});
            r_c2   <= c2;
            r_d1   <= i_depth;
            r_b1   <= i_ofs;
            // ray sum
            r_ray  <= RAY_W'(r_p0) + RAY_W'(r_p1) + RAY_W'(r_c2);
            r_d2   <= r_d1;
            r_b2   <= r_b1;
            // scale by depth
            r_prod <= PROD_W'(r_ray) * PROD_W'($signed({1'b0, r_d2}));
            r_b3   <= r_b2;
            // add offset
            r_s    <= S_W'(r_prod) + (S_W'(r_b3) <<< OFS_SHIFT);
            // magnitude divided by 64, flag anything far out of range
            r_t    <= u[DIV_SHIFT +: T_W];
            r_big5 <= |u[S_W-1:DIV_SHIFT+T_W];
            r_neg5 <= s_neg;
            // divide by 125 through the reciprocal
            r_q    <= m[RECIP_SHIFT +: PT_W];
            r_big6 <= r_big5;
            r_neg6 <= r_neg5;
        end
    end

endmodule

// ===== src/dtpb_back.sv =====
// back end: three coordinate lanes, point index and the output register
// depends on dtpb_pkg, dtpb_ifs, dtpb_axis
module dtpb_back import dtpb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_job       i_job,
    input  logic       i_empty,
    output logic       o_pop,
    dtpb_pt_if.source  o_pt
);

    localparam int NSTG = 6;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             fe;
    } t_side;

    logic [NSTG-1:0]        r_vld;
    logic                   r_ovld;
    logic [IDX_W-1:0]       r_rw1;
    logic [CNT_W-1:0]       r_col1;
    logic                   r_fe1;
    t_side                  r_side [2:NSTG];
    logic signed [PT_W-1:0] r_x, r_y, r_z;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_clip, r_fe;

    logic                   en;
    logic signed [PT_W-1:0] cx, cy, cz;
    logic                   sx, sy, sz;

    // whole pipeline holds while the output waits
    assign en    = !r_ovld || o_pt.ready;
    assign o_pop = en;

    dtpb_axis u_axis_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coef  (i_cfg.ray_x),
        .i_ofs   ($signed(i_cfg.ofs[0 +: COEF_W])),
        .i_col   (i_job.col),
        .i_row   (i_job.row),
        .i_depth (i_job.depth),
        .o_coord (cx),
        .o_sat   (sx)
    );

    dtpb_axis u_axis_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coef  (i_cfg.ray_y),
        .i_ofs   ($signed(i_cfg.ofs[COEF_W +: COEF_W])),
        .i_col   (i_job.col),
        .i_row   (i_job.row),
        .i_depth (i_job.depth),
        .o_coord (cy),
        .o_sat   (sy)
    );

    dtpb_axis u_axis_z (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coef  (i_cfg.ray_z),
        .i_ofs   ($signed(i_cfg.ofs[2*COEF_W +: COEF_W])),
        .i_col   (i_job.col),
        .i_row   (i_job.row),
        .i_depth (i_job.depth),
        .o_coord (cz),
        .o_sat   (sz)
    );

    // stage valid bits and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (en) begin
            r_vld  <= {r_vld[NSTG-2:0], !i_empty};
            r_ovld <= r_vld[NSTG-1];
        end
    end

    // point index alongside the lanes
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rw1  <= IDX_W'(i_job.row) * IDX_W'(i_cfg.width);
            r_col1 <= i_job.col;
            r_fe1  <= i_job.frame_end;
            r_side[2].idx <= IDX_W'(i_cfg.cloud_offset) + r_rw1 + IDX_W'(r_col1);
            r_side[2].fe  <= r_fe1;
            for (int k = 3; k <= NSTG; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x    <= cx;
            r_y    <= cy;
            r_z    <= cz;
            r_clip <= sx || sy || sz;
            r_idx  <= r_side[NSTG].idx;
            r_fe   <= r_side[NSTG].fe;
        end
    end

    assign o_pt.valid       = r_ovld;
    assign o_pt.point_x     = r_x;
    assign o_pt.point_y     = r_y;
    assign o_pt.point_z     = r_z;
    assign o_pt.point_index = r_idx;
    assign o_pt.clipped     = r_clip;
    assign o_pt.frame_end   = r_fe;

endmodule

// ===== src/depth_to_point_backprojection.sv =====
// top level of the depth back-projection block: registers, front, queue, back
// depends on dtpb_pkg, dtpb_ifs, dtpb_front, dtpb_queue, dtpb_back
//
//   channel   dir   handshake      payload
//   i_px      in    valid/ready    depth_mm, frame_start
//   o_pt      out   valid/ready    point_x/y/z, point_index, clipped, frame_end
//   i_cfg     in    valid/ready    index, data (ready always high)
//
// one sample per cycle sustained while the output is not stalled; a taken sample
// passes the queue, then the six lane stages (two multiplier stages for the ray and
// depth, one for the divide by 125), then the output register.
// reset is synchronous: counters, queue and valid bits clear, registers load
// their defaults. a stalled output freezes the back end; the 4-entry queue
// keeps the input open until it fills.
module depth_to_point_backprojection import dtpb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dtpb_px_if.sink    i_px,
    dtpb_pt_if.source  o_pt,
    dtpb_cfg_if.sink   i_cfg
);

    logic [CFG_W-1:0]  r_ray_x, r_ray_y, r_ray_z, r_ofs;
    logic [SIZE_W-1:0] r_width, r_height;
    logic [OFS_W-1:0]  r_cloud;
    t_cfg              cfg;
    logic              push, full, pop, empty;
    t_job              job_in, job_out;

    assign i_cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ray_x  <= '0;
            r_ray_y  <= '0;
            r_ray_z  <= '0;
            r_ofs    <= '0;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_cloud  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_RAY_X:  r_ray_x  <= i_cfg.data;
                REG_RAY_Y:  r_ray_y  <= i_cfg.data;
                REG_RAY_Z:  r_ray_z  <= i_cfg.data;
                REG_OFFSET: r_ofs    <= i_cfg.data;
                REG_WIDTH:  r_width  <= i_cfg.data[SIZE_W-1:0];
                REG_HEIGHT: r_height <= i_cfg.data[SIZE_W-1:0];
                REG_CLOUD:  r_cloud  <= i_cfg.data[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    // sizes clamped to the supported frame
    always_comb begin
        cfg.ray_x        = r_ray_x;
        cfg.ray_y        = r_ray_y;
        cfg.ray_z        = r_ray_z;
        cfg.ofs          = r_ofs;
        cfg.width        = clamp_size(r_width, (SIZE_W+1)'(MAX_WIDTH));
        cfg.height       = clamp_size(r_height, (SIZE_W+1)'(MAX_HEIGHT));
        cfg.cloud_offset = r_cloud;
    end

    dtpb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_px    (i_px),
        .i_cfg   (cfg),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job_in)
    );

    dtpb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_rdata (job_out),
        .o_empty (empty)
    );

    dtpb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_job   (job_out),
        .i_empty (empty),
        .o_pop   (pop),
        .o_pt    (o_pt)
    );

endmodule

// ===== src/dtpb_checker.sv =====
// port-level checks of the depth back-projection block, bound to the top level
// depends on dtpb_pkg and the assertion macro header
`include "depth_to_point_backprojection_defines.svh"

module dtpb_checker import dtpb_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_px_valid,
    input logic                   i_px_ready,
    input logic                   i_pt_valid,
    input logic                   i_pt_ready,
    input logic signed [PT_W-1:0] i_pt_x,
    input logic signed [PT_W-1:0] i_pt_y,
    input logic signed [PT_W-1:0] i_pt_z,
    input logic [IDX_W-1:0]       i_pt_index,
    input logic                   i_pt_clipped,
    input logic                   i_pt_frame_end
);

    logic [4:0]              r_cnt, n_cnt;
    logic                    in_acc, out_acc;
    logic                    stall, none_open, clip_seen, at_rail;
    logic [3*PT_W+IDX_W+1:0] pt_data;

    // samples taken but not yet delivered
    assign in_acc  = i_px_valid && i_px_ready;
    assign out_acc = i_pt_valid && i_pt_ready;
    assign n_cnt   = r_cnt + 5'(in_acc) - 5'(out_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // helper terms for the properties
    assign stall     = i_pt_valid && !i_pt_ready;
    assign none_open = (r_cnt == '0);
    assign clip_seen = i_pt_valid && i_pt_clipped;
    assign pt_data   = {i_pt_x, i_pt_y, i_pt_z, i_pt_index, i_pt_clipped, i_pt_frame_end};
    assign at_rail   = ($unsigned(i_pt_x) == Q_POS_MAX) || ($unsigned(i_pt_x) == Q_NEG_MAX)
                    || ($unsigned(i_pt_y) == Q_POS_MAX) || ($unsigned(i_pt_y) == Q_NEG_MAX)
                    || ($unsigned(i_pt_z) == Q_POS_MAX) || ($unsigned(i_pt_z) == Q_NEG_MAX);

    // a waiting point keeps its payload
    `DTPB_ASSERT_RST(a_pt_hold, i_clk, i_rst_n, stall |=> $stable(pt_data), "point moved in stall")

    // output is quiet right after reset
    `DTPB_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !i_pt_valid, "point valid after reset")

    // no point without a sample in flight
    `DTPB_ASSERT_RST(a_no_phantom, i_clk, i_rst_n, i_pt_valid |-> !none_open, "point from nowhere")

    // a clipped point has a coordinate at a rail
    `DTPB_ASSERT_RST(a_clip_rail, i_clk, i_rst_n, clip_seen |-> at_rail, "clipped point off rail")

endmodule

bind depth_to_point_backprojection dtpb_checker u_dtpb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_px_valid     (i_px.valid),
    .i_px_ready     (i_px.ready),
    .i_pt_valid     (o_pt.valid),
    .i_pt_ready     (o_pt.ready),
    .i_pt_x         (o_pt.point_x),
    .i_pt_y         (o_pt.point_y),
    .i_pt_z         (o_pt.point_z),
    .i_pt_index     (o_pt.point_index),
    .i_pt_clipped   (o_pt.clipped),
    .i_pt_frame_end (o_pt.frame_end)
);

// ===== tb/sv/point_cloud_checker.sv =====
// point checker for the depth back-projection block: predicts every point from
// the depth and register transactions and compares it with the output transactions
// depends on dtpb_pkg and the channel interfaces in dtpb_ifs
`timescale 1ns / 100ps

module point_cloud_checker import dtpb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    dtpb_px_if   i_px,
    dtpb_pt_if   i_pt,
    dtpb_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_points,
    output int   o_clipped,
    output int   o_frame_ends
);

    // fixed-point scaling of one coordinate
    localparam longint OFS_TO_Q19  = 32768;   // Q16.4 mm up to 19 fraction bits
    localparam longint Q19_MM_TO_M = 8000;    // 1000 mm per m, 19 -> 16 fraction bits
    localparam longint HALF_STEP   = 4000;
    localparam longint SAT_POS     = 8388607;
    localparam longint SAT_NEG_MAG = 8388608;
    localparam int     MAX_REPORTS = 20;

    typedef struct packed {
        logic [PT_W-1:0]  x, y, z;
        logic [IDX_W-1:0] index;
        logic             clipped;
        logic             frame_end;
    } t_point;

    // local copy of the registers and the raster position
    logic [CFG_W-1:0]  ray_rows [3];
    logic [CFG_W-1:0]  mm_offsets;
    logic [SIZE_W-1:0] cols_cfg;
    logic [SIZE_W-1:0] rows_cfg;
    logic [OFS_W-1:0]  cloud_base;
    logic [CNT_W-1:0]  col_at;
    logic [ROW_W-1:0]  row_at;

    t_point expected_points [$];
    t_point want;

    // signed 20-bit coefficient at a bit position of a packed row
    function automatic longint coef_at(input logic [CFG_W-1:0] coefs, input int pos);
        logic signed [COEF_W-1:0] c;
        c = coefs[pos +: COEF_W];
        return longint'(c);
    endfunction

    // one axis: ray times depth plus offset, rounded half away from zero, saturated
    function automatic logic [PT_W-1:0] metres_q16(input logic [CFG_W-1:0] coefs,
                                                   input longint ofs_q4, input longint col,
                                                   input longint row, input longint depth,
                                                   output bit sat);
        longint ray, sum_q19, mag, q;
        sat = 1'b0;
        ray = coef_at(coefs, 0) * col + coef_at(coefs, COEF_W) * row
            + coef_at(coefs, 2 * COEF_W);
        sum_q19 = ray * depth + ofs_q4 * OFS_TO_Q19;
        mag = (sum_q19 < 0) ? -sum_q19 : sum_q19;
        q = (mag + HALF_STEP) / Q19_MM_TO_M;
        if (sum_q19 >= 0 && q > SAT_POS) begin
            q = SAT_POS;
            sat = 1'b1;
        end
        if (sum_q19 < 0 && q > SAT_NEG_MAG) begin
            q = SAT_NEG_MAG;
            sat = 1'b1;
        end
        if (sum_q19 < 0) q = -q;
        return q[PT_W-1:0];
    endfunction

    // point for one depth sample, then advance the raster position
    function automatic t_point project_pixel(input logic [DEPTH_W-1:0] depth,
                                             input logic start);
        t_point p;
        int     w, h;
        bit     sx, sy, sz, last_col, last_row;
        longint idx;
        w = (cols_cfg == '0) ? 1 : (int'(cols_cfg) > MAX_WIDTH ? MAX_WIDTH : int'(cols_cfg));
        h = (rows_cfg == '0) ? 1 : (int'(rows_cfg) > MAX_HEIGHT ? MAX_HEIGHT : int'(rows_cfg));
        if (start) begin
            col_at = '0;
            row_at = '0;
        end
        p.x = metres_q16(ray_rows[0], coef_at(mm_offsets, 0), col_at, row_at, depth, sx);
        p.y = metres_q16(ray_rows[1], coef_at(mm_offsets, COEF_W), col_at, row_at, depth, sy);
        p.z = metres_q16(ray_rows[2], coef_at(mm_offsets, 2 * COEF_W), col_at, row_at,
                         depth, sz);
        idx = longint'(cloud_base) + longint'(row_at) * w + longint'(col_at);
        p.index = idx[IDX_W-1:0];
        p.clipped = sx | sy | sz;
        // a position at or past the last column or row closes the row or the frame
        last_col = int'(col_at) >= w - 1;
        last_row = int'(row_at) >= h - 1;
        p.frame_end = last_col && last_row;
        if (last_col) begin
            col_at = '0;
            row_at = last_row ? '0 : row_at + 1'b1;
        end else begin
            col_at = col_at + 1'b1;
        end
        return p;
    endfunction

    task automatic check_field(input string name, input longint exp_val, input longint act_val);
        if (exp_val != act_val) begin
            o_fail_count++;
            if (o_fail_count <= MAX_REPORTS) begin
                $display("%0t ns: point %0d %s mismatch: expected %0d, actual %0d",
                         $time, o_points, name, exp_val, act_val);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ray_rows[0] = '0;
            ray_rows[1] = '0;
            ray_rows[2] = '0;
            mm_offsets  = '0;
            cols_cfg    = WIDTH_RST;
            rows_cfg    = HEIGHT_RST;
            cloud_base  = '0;
            col_at      = '0;
            row_at      = '0;
            expected_points.delete();
        end else begin
            // register write transaction
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_RAY_X:  ray_rows[0] = i_cfg.data;
                    REG_RAY_Y:  ray_rows[1] = i_cfg.data;
                    REG_RAY_Z:  ray_rows[2] = i_cfg.data;
                    REG_OFFSET: mm_offsets  = i_cfg.data;
                    REG_WIDTH:  cols_cfg    = i_cfg.data[SIZE_W-1:0];
                    REG_HEIGHT: rows_cfg    = i_cfg.data[SIZE_W-1:0];
                    REG_CLOUD:  cloud_base  = i_cfg.data[OFS_W-1:0];
                    default: ;
                endcase
            end
            // depth transaction: queue its point
            if (i_px.valid && i_px.ready) begin
                expected_points.push_back(project_pixel(i_px.depth_mm, i_px.frame_start));
            end
            // point transaction: compare with the oldest queued point
            if (i_pt.valid && i_pt.ready) begin
                if (expected_points.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= MAX_REPORTS) begin
                        $display("%0t ns: unexpected point transaction, index %0d",
                                 $time, i_pt.point_index);
                    end
                end else begin
                    want = expected_points.pop_front();
                    check_field("point_x", $signed(want.x), i_pt.point_x);
                    check_field("point_y", $signed(want.y), i_pt.point_y);
                    check_field("point_z", $signed(want.z), i_pt.point_z);
                    check_field("point_index", want.index, i_pt.point_index);
                    check_field("clipped", want.clipped, i_pt.clipped);
                    check_field("frame_end", want.frame_end, i_pt.frame_end);
                end
                o_points++;
                o_clipped += i_pt.clipped;
                o_frame_ends += i_pt.frame_end;
            end
        end
        o_pending = expected_points.size();
    end

endmodule

// ===== tb/sv/depth_to_point_backprojection_tb.sv =====
// testbench top for the depth back-projection block: clock, reset, depth and
// register stimulus, output backpressure and the verdict
// depends on dtpb_pkg, dtpb_ifs, the block and point_cloud_checker
`timescale 1ns / 100ps

module depth_to_point_backprojection_tb;
    import dtpb_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 9;
    localparam int SEGMENTS      = 12;
    localparam int SEG_ITEMS     = 112;
    localparam int HOLD_SEG      = 9;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 200000;

    localparam logic [REGI_W-1:0] REG_NONE = 3'd7;
    localparam logic [COEF_W-1:0] COEF_MAX = 20'h7FFFF;
    localparam logic [COEF_W-1:0] COEF_MIN = 20'h80000;
    localparam logic [OFS_W-1:0]  CLOUD_MAX = 24'hFFFFFF;

    logic i_clk;
    logic i_rst_n;

    dtpb_px_if  px_if ();
    dtpb_pt_if  pt_if ();
    dtpb_cfg_if cfg_if ();

    int fail_count;
    int pending;
    int points;
    int clipped_points;
    int frame_ends;

    int src_idle_pct  = 24;
    int sink_idle_pct = 85;
    bit hold_req;
    int frame_len;
    int pix_in_frame;
    int setups;
    int cycle_count;

    depth_to_point_backprojection DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_px    (px_if),
        .o_pt    (pt_if),
        .i_cfg   (cfg_if)
    );

    point_cloud_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_px         (px_if),
        .i_pt         (pt_if),
        .i_cfg        (cfg_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_points     (points),
        .o_clipped    (clipped_points),
        .o_frame_ends (frame_ends)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d points still expected", cycle_count, pending);
        $display("CHECK FAILED");
        $finish;
    end

    // point receiver: random backpressure and one long hold-off
    initial begin
        pt_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                pt_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                pt_if.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // frame size as the block uses it
    function automatic int dim_span(input logic [SIZE_W-1:0] dim);
        if (dim == '0) return 1;
        if (int'(dim) > MAX_WIDTH) return MAX_WIDTH;
        return int'(dim);
    endfunction

    // 20-bit coefficient or offset: near zero, anywhere, or at an extreme
    function automatic logic [COEF_W-1:0] random_coef(input int unsigned span);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45) return COEF_W'($urandom_range(2 * span) - span);
        if (pick < 75) return COEF_W'($urandom);
        if (pick < 88) return COEF_MAX;
        return COEF_MIN;
    endfunction

    function automatic logic [CFG_W-1:0] random_triple(input int unsigned span);
        return {3'($urandom_range(7)), random_coef(span), random_coef(span),
                random_coef(span)};
    endfunction

    function automatic logic [SIZE_W-1:0] random_dim();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 78) return SIZE_W'($urandom_range(1, 9));
        if (pick < 84) return '0;
        if (pick < 90) return SIZE_W'($urandom_range(4097, 8191));
        if (pick < 95) return SIZE_W'(MAX_WIDTH);
        return SIZE_W'($urandom_range(10, 64));
    endfunction

    function automatic logic [OFS_W-1:0] random_cloud();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15) return '0;
        if (pick < 30) return CLOUD_MAX;
        return OFS_W'($urandom);
    endfunction

    function automatic logic [DEPTH_W-1:0] random_depth();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10) return '0;
        if (pick < 20) return '1;
        if (pick < 60) return DEPTH_W'($urandom_range(200, 10000));
        return DEPTH_W'($urandom);
    endfunction

    // one register write transaction; valid stays high for a following write
    task automatic write_reg(input logic [REGI_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
    endtask

    // full register setup, only while the block is idle
    task automatic apply_setup(input logic [CFG_W-1:0] ray_x, input logic [CFG_W-1:0] ray_y,
                               input logic [CFG_W-1:0] ray_z, input logic [CFG_W-1:0] ofs,
                               input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                               input logic [OFS_W-1:0] cloud);
        write_reg(REG_RAY_X, ray_x);
        write_reg(REG_RAY_Y, ray_y);
        write_reg(REG_RAY_Z, ray_z);
        write_reg(REG_OFFSET, ofs);
        write_reg(REG_WIDTH, CFG_W'(w));
        write_reg(REG_HEIGHT, CFG_W'(h));
        write_reg(REG_CLOUD, CFG_W'(cloud));
        cfg_if.valid <= 1'b0;
        frame_len = dim_span(w) * dim_span(h);
        setups++;
    endtask

    // one depth transaction, sometimes with a random gap before it
    task automatic send_pixel(input logic [DEPTH_W-1:0] depth, input logic start);
        if ($urandom_range(99) < src_idle_pct) begin
            px_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        px_if.valid       <= 1'b1;
        px_if.depth_mm    <= depth;
        px_if.frame_start <= start;
        do @(posedge i_clk); while (!px_if.ready);
    endtask

    // stop sending and wait for every queued point
    task automatic wait_idle();
        px_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        logic start;
        i_rst_n            = 1'b0;
        hold_req           = 1'b0;
        px_if.valid        = 1'b0;
        px_if.depth_mm     = '0;
        px_if.frame_start  = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = REG_RAY_X;
        cfg_if.data        = '0;
        setups             = 0;
        pix_in_frame       = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: zero rays and offsets put every point at the origin
        send_pixel('1, 1'b1);
        send_pixel('0, 1'b0);
        wait_idle();

        // full-scale rays saturate both ways, extreme offsets and cloud base,
        // an ignored register index, zero depth, frame start in mid-frame
        write_reg(REG_NONE, CFG_W'({$urandom, $urandom}));
        apply_setup({3'b111, COEF_MAX, COEF_MAX, COEF_MAX},
                    {3'b000, COEF_MIN, COEF_MIN, COEF_MIN},
                    {3'b010, COEF_MAX, 20'd0, 20'd0},
                    {3'b100, 20'd0, COEF_MIN, COEF_MAX},
                    SIZE_W'(4), SIZE_W'(2), CLOUD_MAX);
        send_pixel('0, 1'b1);
        send_pixel('1, 1'b0);
        send_pixel(DEPTH_W'(1), 1'b0);
        send_pixel('1, 1'b0);
        send_pixel(DEPTH_W'(16'h8000), 1'b0);
        send_pixel('0, 1'b0);
        send_pixel('1, 1'b0);
        send_pixel(DEPTH_W'(12345), 1'b0);
        send_pixel('1, 1'b0);
        send_pixel(DEPTH_W'(100), 1'b1);
        send_pixel('1, 1'b0);
        wait_idle();

        // zero sizes clamp to one: every pixel ends a frame
        apply_setup({3'b111, COEF_MAX, COEF_MAX, COEF_MAX},
                    {3'b000, COEF_MIN, COEF_MIN, COEF_MIN},
                    {3'b010, COEF_MAX, 20'd0, 20'd0},
                    {3'b100, 20'd0, COEF_MIN, COEF_MAX},
                    '0, '0, '0);
        send_pixel('1, 1'b0);
        send_pixel(DEPTH_W'(500), 1'b1);
        send_pixel('1, 1'b0);
        wait_idle();

        // oversized frame clamps to the maximum
        apply_setup({3'b001, COEF_MIN, COEF_MAX, COEF_MIN},
                    {3'b110, COEF_MAX, COEF_MIN, COEF_MAX},
                    {3'b011, COEF_MAX, 20'd0, 20'd0},
                    {3'b000, COEF_MAX, COEF_MAX, COEF_MIN},
                    '1, '1, CLOUD_MAX);
        send_pixel('1, 1'b1);
        send_pixel('1, 1'b0);
        send_pixel(DEPTH_W'(1000), 1'b0);

        // random setups with mostly well-formed frames of random depth
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            src_idle_pct  = (seg < 4) ? 24 : (seg < 8) ? 85 : 0;
            sink_idle_pct = (seg < 4) ? 85 : (seg < 8) ? 24 : 0;
            wait_idle();
            if ($urandom_range(3) == 0) write_reg(REG_NONE, CFG_W'({$urandom, $urandom}));
            apply_setup(random_triple(2000), random_triple(2000), random_triple(2000),
                        random_triple(20000), random_dim(), random_dim(), random_cloud());
            // sometimes the raster position carries over into the new size
            if ($urandom_range(99) < 70) pix_in_frame = 0;
            else pix_in_frame = pix_in_frame % frame_len;
            for (int n = 0; n < SEG_ITEMS; n++) begin
                if (seg == HOLD_SEG && n == SEG_ITEMS / 2) hold_req = 1'b1;
                start = (pix_in_frame == 0);
                if ($urandom_range(99) < 4) start = ~start;
                if (start) pix_in_frame = 0;
                send_pixel(random_depth(), start);
                pix_in_frame = (pix_in_frame + 1) % frame_len;
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("run covered %0d points from %0d register setups: %0d clipped, %0d frame ends",
                 points, setups, clipped_points, frame_ends);
        $display("sender-heavy, receiver-heavy and no idling, one %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
